### sv/bht_pkg.sv
// Shared types and constants of the bucketed hash table.
// Used by bht_mod and bucketed_hash_table_top; depends on nothing.
`default_nettype none

package bht_pkg;

    localparam int unsigned KEY_W      = 31;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned PROBE_W    = 4;
    localparam int unsigned BC_W       = 5;
    localparam int unsigned SU_W       = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned WORD_W     = KEY_W + 1;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd1;

    localparam logic [BC_W-1:0] BUCKET_COUNT_RST = 5'd16;
    localparam logic [SU_W-1:0] SLOTS_IN_USE_RST = 4'd8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN
    } state_t;

endpackage

`default_nettype wire

### sv/bht_mod.sv
// Serial remainder unit: key modulo bucket count, two quotient bits per cycle.
// Depends on bht_pkg.
`default_nettype none

module bht_mod (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic [bht_pkg::KEY_W-1:0] dividend,
    input  wire logic [bht_pkg::BC_W-1:0]  divisor,
    output logic                          done,
    output logic [bht_pkg::BC_W-1:0]       rem
);
    import bht_pkg::*;

    localparam int unsigned STEPS = (KEY_W + 1) / 2;
    localparam int unsigned NUM_W = 2 * STEPS;
    localparam int unsigned CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [BC_W-1:0]  rem_reg, rem_next;
    logic [BC_W-1:0]  div_reg, div_next;
    logic [BC_W-1:0]  rem_hi;
    logic [BC_W-1:0]  rem_lo;

    // One restoring step; the partial remainder stays below the divisor.
    function automatic logic [BC_W-1:0] rem_step(
        input logic [BC_W-1:0] r,
        input logic            b,
        input logic [BC_W-1:0] d
    );
        logic [BC_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            return BC_W'(t - {1'b0, d});
        end
        return t[BC_W-1:0];
    endfunction

    assign rem_hi = rem_step(rem_reg, num_reg[NUM_W-1], div_reg);
    assign rem_lo = rem_step(rem_hi, num_reg[NUM_W-2], div_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS - 1);
            num_next  = NUM_W'(dividend);
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-3:0], 2'b00};
            rem_next = rem_lo;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

`ifndef ASSERT_OFF
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < div_reg))
        else $error("partial remainder not below divisor");

    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("done without a finished run");

    a_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy_reg)
        else $error("load while a run is in progress");
`endif

endmodule

`default_nettype wire

### sv/bht_mem.sv
// Slot store: one word per slot, valid bit over the key.
// One write port, one read port with registered read data; no package use.
`default_nettype none

module bht_mem #(
    parameter int unsigned DEPTH = 128,
    parameter int unsigned AW    = 7,
    parameter int unsigned W     = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [W-1:0]       rdata
);
    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/bucketed_hash_table_top.sv
// Top level of the bucketed hash table: sequencer, slot scan and config registers.
// Depends on bht_pkg, bht_mod and bht_mem.
`default_nettype none

// Bucketed hash table with modulo hash. After reset the block clears its slot
// store, one slot per cycle, with busy high; config writes are taken
// throughout. An operation is accepted when start is high and busy is low.
// The bucket comes from a serial remainder unit that retires two key bits per
// cycle, then the slots of the bucket are read one per cycle from the store's
// single read port, the compare following in the cycle after the read. The
// result shows with done for one cycle; an unused action code answers in the
// next cycle. There is no backpressure on the result side: sample probes and
// status while done is high.
// The next operation may start in the cycle that done is shown.
module bucketed_hash_table_top #(
    parameter int unsigned BUCKETS = 16,
    parameter int unsigned WAYS    = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [bht_pkg::ACT_W-1:0]      action,
    input  wire logic [bht_pkg::KEY_W-1:0]      key,
    output logic                                done,
    output logic [bht_pkg::PROBE_W-1:0]         probes,
    output logic                                status,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bht_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bht_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bht_pkg::*;

    localparam int unsigned DEPTH = BUCKETS * WAYS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BMAX  = (BUCKETS < 31) ? BUCKETS : 31;
    localparam int unsigned WMAX  = (WAYS < 15) ? WAYS : 15;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [SU_W-1:0]      ns_reg, ns_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [SU_W-1:0]      iss_reg, iss_next;
    logic [SU_W-1:0]      chk_reg, chk_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic                 done_reg, done_next;
    logic [PROBE_W-1:0]   probes_reg, probes_next;
    logic                 status_reg, status_next;
    logic [BC_W-1:0]      bucket_count_reg;
    logic [SU_W-1:0]      slots_in_use_reg;

    logic [BC_W-1:0]      nb_eff;
    logic [SU_W-1:0]      ns_eff;
    logic                 div_load;
    logic                 div_done;
    logic [BC_W-1:0]      div_rem;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_W-1:0]    mem_rdata;
    logic                 slot_full;
    logic                 slot_hit;

    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            nb_eff = BC_W'(1);
        end
        else if (32'(bucket_count_reg) > BMAX)
        begin
            nb_eff = BC_W'(BMAX);
        end
        else
        begin
            nb_eff = bucket_count_reg;
        end

        if (slots_in_use_reg == '0)
        begin
            ns_eff = SU_W'(1);
        end
        else if (32'(slots_in_use_reg) > WMAX)
        begin
            ns_eff = SU_W'(WMAX);
        end
        else
        begin
            ns_eff = slots_in_use_reg;
        end
    end

    bht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (div_load),
        .dividend (key),
        .divisor  (nb_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    bht_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .W     (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Insert wants an empty slot; search and remove want an occupied match.
    assign slot_full = mem_rdata[WORD_W-1];
    assign slot_hit  = (act_reg == ACT_INSERT) ? !slot_full
                     : (slot_full && (mem_rdata[KEY_W-1:0] == key_reg));

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        ns_next       = ns_reg;
        base_next     = base_reg;
        iss_next      = iss_reg;
        chk_next      = chk_reg;
        chk_vld_next  = chk_vld_reg;
        done_next     = 1'b0;
        probes_next   = probes_reg;
        status_next   = status_reg;
        div_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = base_reg + AW'(chk_reg);
        mem_wdata     = {1'b1, key_reg};
        mem_raddr     = base_reg + AW'(iss_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (action inside {ACT_INSERT, ACT_SEARCH, ACT_REMOVE})
                    begin
                        act_next   = action;
                        key_next   = key;
                        ns_next    = ns_eff;
                        div_load   = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        // unused code: leave the table alone
                        done_next   = 1'b1;
                        probes_next = '0;
                        status_next = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    base_next    = AW'(32'(div_rem) * 32'(WAYS));
                    iss_next     = '0;
                    chk_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue the next slot read while the previous one is compared
                if (iss_reg != ns_reg)
                begin
                    iss_next     = iss_reg + 1'b1;
                    chk_next     = iss_reg;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                if (chk_vld_reg)
                begin
                    if (slot_hit)
                    begin
                        mem_we      = (act_reg != ACT_SEARCH);
                        mem_wdata   = (act_reg == ACT_INSERT) ? {1'b1, key_reg} : '0;
                        done_next   = 1'b1;
                        probes_next = PROBE_W'(chk_reg + 1'b1);
                        status_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else if (chk_reg == ns_reg - 1'b1)
                    begin
                        done_next   = 1'b1;
                        probes_next = PROBE_W'(ns_reg);
                        status_next = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            chk_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            chk_vld_reg  <= chk_vld_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        ns_reg     <= ns_next;
        base_reg   <= base_next;
        iss_reg    <= iss_next;
        chk_reg    <= chk_next;
        probes_reg <= probes_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
            slots_in_use_reg <= SLOTS_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data[BC_W-1:0];
                REG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[SU_W-1:0];
                default:          ;
            endcase
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign probes    = probes_reg;
    assign status    = status_reg;
    assign cfg_ready = 1'b1;

`ifndef ASSERT_OFF
    a_success_probes: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !status_reg) |-> (probes_reg != '0))
        else $error("success reported with zero probes");

    a_unused_action: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action != ACT_INSERT && action != ACT_SEARCH
            && action != ACT_REMOVE)
        |=> (done_reg && probes_reg == '0 && status_reg))
        else $error("unused action code not answered at once");

    a_miss_probes: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg && probes_reg != '0) |-> (probes_reg == PROBE_W'(ns_reg)))
        else $error("miss count differs from slots scanned");

    a_search_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_SCAN) |-> (act_reg != ACT_SEARCH))
        else $error("search modified the store");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !done_reg)
        else $error("result during clearing pass");
`endif

endmodule

`default_nettype wire
